>>> src/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define SEGINT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define SEGINT_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> src/segint_pkg.sv
// Shared widths and types of the segment intersection unit.
// No dependencies; the other source files of the block use it, apart from assert_macros.svh.
package segint_pkg;

	localparam int COORD_BITS = 12;
	// Line coefficients a and b, and the constant term c.
	localparam int LW = COORD_BITS + 2;
	localparam int CW = 2 * COORD_BITS + 2;
	// Side values and determinant.
	localparam int SW = 2 * COORD_BITS + 5;
	// Intersection numerators.
	localparam int NW = 3 * COORD_BITS + 5;
	// Quotient magnitude: a hit point stays within one bit beyond the coordinate range.
	localparam int QW = COORD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [NW-1:0] num_mag_t;
	typedef logic [SW-1:0] den_mag_t;
	typedef logic [QW-1:0] quo_t;

	typedef struct packed {
		logic hit;
		logic neg;
	} div_meta_t;

endpackage

>>> src/segint_in_if.sv
// Valid/ready channels of the segment intersection unit: segment pairs in, results out.
// Depends on segint_pkg for the coordinate width.
interface segint_in_if;
	logic valid;
	logic ready;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_a_x0;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_a_y0;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_a_x1;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_a_y1;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_b_x0;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_b_y0;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_b_x1;
	logic signed [segint_pkg::COORD_BITS-1:0] seg_b_y1;

	modport source(output valid, seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1,
		seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1, input ready);
	modport sink(input valid, seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1,
		seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1, output ready);
endinterface

interface segint_out_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [segint_pkg::COORD_BITS-1:0] cross_x;
	logic signed [segint_pkg::COORD_BITS-1:0] cross_y;

	modport source(output valid, hit, cross_x, cross_y, input ready);
	modport sink(input valid, hit, cross_x, cross_y, output ready);
endinterface

>>> src/segment_intersection_unit.sv
// Segment intersection unit: line equations, side tests, determinant and rounded division.
// Depends on segint_pkg, segint_in_if/segint_out_if and segint_div.
//
// One segment pair is taken in every cycle while the pipeline is not halted. Each pair passes
// through 4 + COORD_BITS + 2 register stages, and the two bit-serial quotient pipelines
// set that length. The whole pipeline moves together and halts only while a result sits
// in the output register and the consumer is not ready.
module segment_intersection_unit (
	input logic          clk,
	input logic          arst_n,
	segint_in_if.sink    seg_in,
	segint_out_if.source seg_out
);
	import segint_pkg::*;

	localparam logic signed [QW:0] VMax = (QW + 1)'(2 ** (COORD_BITS - 1) - 1);
	localparam logic signed [QW:0] VMin = -VMax - (QW + 1)'(1);

	logic en;
	logic out_vld_q;

	assign en           = !out_vld_q || seg_out.ready;
	assign seg_in.ready = en;

	// Stage 1: line coefficients.
	logic                 vld_s1;
	logic signed [LW-1:0] la_s1, lb_s1, ma_s1, mb_s1;
	logic signed [CW-1:0] lc_s1, mc_s1;
	coord_t               ax0_s1, ay0_s1, ax1_s1, ay1_s1, bx0_s1, by0_s1, bx1_s1, by1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			la_s1  <= LW'(seg_in.seg_a_y1) - LW'(seg_in.seg_a_y0);
			lb_s1  <= LW'(seg_in.seg_a_x0) - LW'(seg_in.seg_a_x1);
			lc_s1  <= CW'(seg_in.seg_a_x1) * CW'(seg_in.seg_a_y0)
				- CW'(seg_in.seg_a_x0) * CW'(seg_in.seg_a_y1);
			ma_s1  <= LW'(seg_in.seg_b_y1) - LW'(seg_in.seg_b_y0);
			mb_s1  <= LW'(seg_in.seg_b_x0) - LW'(seg_in.seg_b_x1);
			mc_s1  <= CW'(seg_in.seg_b_x1) * CW'(seg_in.seg_b_y0)
				- CW'(seg_in.seg_b_x0) * CW'(seg_in.seg_b_y1);
			ax0_s1 <= seg_in.seg_a_x0;
			ay0_s1 <= seg_in.seg_a_y0;
			ax1_s1 <= seg_in.seg_a_x1;
			ay1_s1 <= seg_in.seg_a_y1;
			bx0_s1 <= seg_in.seg_b_x0;
			by0_s1 <= seg_in.seg_b_y0;
			bx1_s1 <= seg_in.seg_b_x1;
			by1_s1 <= seg_in.seg_b_y1;
		end
	end

	// Stage 2: every product of the side values, determinant and numerators.
	logic                 vld_s2;
	logic signed [SW-1:0] pb0x_s2, pb0y_s2, pb1x_s2, pb1y_s2;
	logic signed [SW-1:0] pa0x_s2, pa0y_s2, pa1x_s2, pa1y_s2;
	logic signed [SW-1:0] d1_s2, d2_s2;
	logic signed [NW-1:0] nx1_s2, nx2_s2, ny1_s2, ny2_s2;
	logic signed [CW-1:0] lc_s2, mc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pb0x_s2 <= SW'(la_s1) * SW'(bx0_s1);
			pb0y_s2 <= SW'(lb_s1) * SW'(by0_s1);
			pb1x_s2 <= SW'(la_s1) * SW'(bx1_s1);
			pb1y_s2 <= SW'(lb_s1) * SW'(by1_s1);
			pa0x_s2 <= SW'(ma_s1) * SW'(ax0_s1);
			pa0y_s2 <= SW'(mb_s1) * SW'(ay0_s1);
			pa1x_s2 <= SW'(ma_s1) * SW'(ax1_s1);
			pa1y_s2 <= SW'(mb_s1) * SW'(ay1_s1);
			d1_s2   <= SW'(la_s1) * SW'(mb_s1);
			d2_s2   <= SW'(ma_s1) * SW'(lb_s1);
			nx1_s2  <= NW'(lb_s1) * NW'(mc_s1);
			nx2_s2  <= NW'(mb_s1) * NW'(lc_s1);
			ny1_s2  <= NW'(ma_s1) * NW'(lc_s1);
			ny2_s2  <= NW'(la_s1) * NW'(mc_s1);
			lc_s2   <= lc_s1;
			mc_s2   <= mc_s1;
		end
	end

	// Stage 3: side values, rejection and the sums.
	logic                 vld_s3;
	logic                 hit_s3;
	logic signed [SW-1:0] det_s3;
	logic signed [NW-1:0] numx_s3, numy_s3;
	logic signed [SW-1:0] sb0, sb1, sa0, sa1, det_c;
	logic                 same_b, same_a;

	always_comb begin
		sb0    = pb0x_s2 + pb0y_s2 + SW'(lc_s2);
		sb1    = pb1x_s2 + pb1y_s2 + SW'(lc_s2);
		sa0    = pa0x_s2 + pa0y_s2 + SW'(mc_s2);
		sa1    = pa1x_s2 + pa1y_s2 + SW'(mc_s2);
		det_c  = d1_s2 - d2_s2;
		same_b = (sb0 > 0 && sb1 > 0) || (sb0 < 0 && sb1 < 0);
		same_a = (sa0 > 0 && sa1 > 0) || (sa0 < 0 && sa1 < 0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3  <= !same_b && !same_a && (det_c != '0);
			det_s3  <= det_c;
			numx_s3 <= nx1_s2 - nx2_s2;
			numy_s3 <= ny1_s2 - ny2_s2;
		end
	end

	// Stage 4: round half away from zero, then split into sign and magnitude.
	logic                 vld_s4;
	div_meta_t            mx_s4, my_s4;
	num_mag_t             magx_s4, magy_s4;
	den_mag_t             den_s4;
	logic signed [SW-1:0] dabs, half;
	logic signed [NW-1:0] rx, ry;

	always_comb begin
		dabs = det_s3[SW-1] ? -det_s3 : det_s3;
		half = dabs >>> 1;
		rx   = numx_s3[NW-1] ? numx_s3 - NW'(half) : numx_s3 + NW'(half);
		ry   = numy_s3[NW-1] ? numy_s3 - NW'(half) : numy_s3 + NW'(half);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4    <= den_mag_t'(dabs);
			magx_s4   <= num_mag_t'(rx[NW-1] ? -rx : rx);
			magy_s4   <= num_mag_t'(ry[NW-1] ? -ry : ry);
			mx_s4.hit <= hit_s3;
			mx_s4.neg <= rx[NW-1] ^ det_s3[SW-1];
			my_s4.hit <= hit_s3;
			my_s4.neg <= ry[NW-1] ^ det_s3[SW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= seg_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	logic      dx_vld, dy_vld;
	div_meta_t dx_meta, dy_meta;
	quo_t      dx_quo, dy_quo;

	segint_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.meta_i (mx_s4),
		.num_i  (magx_s4),
		.den_i  (den_s4),
		.vld_o  (dx_vld),
		.meta_o (dx_meta),
		.quo_o  (dx_quo)
	);

	segint_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.meta_i (my_s4),
		.num_i  (magy_s4),
		.den_i  (den_s4),
		.vld_o  (dy_vld),
		.meta_o (dy_meta),
		.quo_o  (dy_quo)
	);

	function automatic coord_t fit(input logic neg, input quo_t mag);
		logic signed [QW:0] v;
		v = signed'({1'b0, mag});
		if (neg) begin
			v = -v;
		end
		if (v > VMax) begin
			v = VMax;
		end
		if (v < VMin) begin
			v = VMin;
		end
		return coord_t'(v[COORD_BITS-1:0]);
	endfunction

	// Output register.
	logic   hit_q;
	coord_t cross_x_q, cross_y_q;
	logic   hit_c;

	assign hit_c = dx_meta.hit && dy_meta.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dx_vld && dy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q     <= hit_c;
			cross_x_q <= hit_c ? fit(dx_meta.neg, dx_quo) : '0;
			cross_y_q <= hit_c ? fit(dy_meta.neg, dy_quo) : '0;
		end
	end

	assign seg_out.valid   = out_vld_q;
	assign seg_out.hit     = hit_q;
	assign seg_out.cross_x = cross_x_q;
	assign seg_out.cross_y = cross_y_q;

endmodule

>>> src/segint_div.sv
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
// Depends on segint_pkg; side information travels in lockstep with each item.
module segint_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  segint_pkg::div_meta_t meta_i,
	input  segint_pkg::num_mag_t  num_i,
	input  segint_pkg::den_mag_t  den_i,
	output logic                  vld_o,
	output segint_pkg::div_meta_t meta_o,
	output segint_pkg::quo_t      quo_o
);
	import segint_pkg::*;

	logic      vld_s  [QW];
	div_meta_t meta_s [QW];
	num_mag_t  rem_s  [QW];
	den_mag_t  den_s  [QW];
	quo_t      quo_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int J = QW - 1 - k;
		logic          vld_p;
		div_meta_t     meta_p;
		num_mag_t      rem_p;
		den_mag_t      den_p;
		quo_t          quo_p;
		logic [NW:0]   trial;
		quo_t          quo_n;

		if (k == 0) begin : g_first
			assign vld_p  = vld_i;
			assign meta_p = meta_i;
			assign rem_p  = num_i;
			assign den_p  = den_i;
			assign quo_p  = '0;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign meta_p = meta_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign den_p  = den_s[k-1];
			assign quo_p  = quo_s[k-1];
		end

		// The shifted divisor always fits, so the top bit of the difference is its sign.
		always_comb begin
			trial    = {1'b0, rem_p} - ((NW + 1)'(den_p) << J);
			quo_n    = quo_p;
			quo_n[J] = ~trial[NW];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= meta_p;
				den_s[k]  <= den_p;
				quo_s[k]  <= quo_n;
				rem_s[k]  <= trial[NW] ? rem_p : trial[NW-1:0];
			end
		end
	end

	assign vld_o  = vld_s[QW-1];
	assign meta_o = meta_s[QW-1];
	assign quo_o  = quo_s[QW-1];

endmodule

>>> src/segint_chk.sv
// Port-level checker of the segment intersection unit, attached by the bind below.
// Depends on segint_pkg and assert_macros.svh.
`include "assert_macros.svh"

module segint_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic           hit,
	input segint_pkg::coord_t cross_x,
	input segint_pkg::coord_t cross_y
);
	import segint_pkg::*;

	// A miss always reports the origin.
	`SEGINT_ASSERT(a_miss_zero, out_valid && !hit |-> cross_x == '0 && cross_y == '0, "miss with nonzero point")

	// A result that is not taken stays put.
	`SEGINT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(cross_x) && $stable(cross_y), "result changed while stalled")

	// With nothing waiting at the output the unit always takes an item.
	`SEGINT_ASSERT_ALWAYS(a_ready_free, !out_valid |-> in_ready, "not ready with empty output")

	// A stalled output blocks the input.
	`SEGINT_ASSERT(a_stall_blocks, out_valid && !out_ready && in_valid |-> !in_ready, "item taken during stall")

endmodule

bind segment_intersection_unit segint_chk u_segint_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (seg_in.valid),
	.in_ready  (seg_in.ready),
	.out_valid (seg_out.valid),
	.out_ready (seg_out.ready),
	.hit       (seg_out.hit),
	.cross_x   (seg_out.cross_x),
	.cross_y   (seg_out.cross_y)
);
